// ===== design/bsp_pkg.sv =====
// Shared types, constants and helpers for the breadth-first search engine.
`timescale 1ns / 1ps
package bsp_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int MAX_DEGREE   = 16;

   // Fixed field widths
   localparam int CMD_W  = 2;
   localparam int VTX_W  = 6;
   localparam int VC_W   = 7;
   localparam int RCNT_W = 7;

   // Derived widths
   localparam int VIDX_W    = $clog2(MAX_VERTICES);
   localparam int CNT_W     = $clog2(MAX_VERTICES + 1);
   localparam int DEG_W     = $clog2(MAX_DEGREE + 1);
   localparam int NBR_DEPTH = MAX_VERTICES * MAX_DEGREE;
   localparam int NBR_AW    = $clog2(NBR_DEPTH);

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_ADD    = 2'd1,
      CMD_SEARCH = 2'd2,
      CMD_QUERY  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE, S_EMIT,
      E_RDA, E_RDB, E_CHK, E_WRB,
      S_INIT, S_POP, S_U, S_UD, S_NRD, S_NCHK,
      Q_START, Q_CHK, Q_PAR, Q_OUT, Q_HOP, Q_EMIT
   } state_type;

   typedef struct packed {
      status_type          status;
      logic [VTX_W-1:0]    path_vertex;
      logic [VTX_W-1:0]    hop_distance;
      logic                reached;
      logic [RCNT_W-1:0]   reached_count;
      logic                last;
   } rsp_type;

   // Neighbor list slot address: vertex row, entry column
   function automatic logic [NBR_AW-1:0] nbr_addr(input logic [VIDX_W-1:0] v,
                                                  input logic [DEG_W-1:0] k);
      nbr_addr = NBR_AW'(v) * NBR_AW'(MAX_DEGREE) + NBR_AW'(k);
   endfunction

endpackage

// ===== design/bsp_core.sv =====
// Command sequencer with graph, search and path memories.
`timescale 1ns / 1ps
module bsp_core import bsp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [CMD_W-1:0]   req_command,
   input  logic [VTX_W-1:0]   req_vertex_a,
   input  logic [VTX_W-1:0]   req_vertex_b,
   input  logic [VC_W-1:0]    vertex_count,
   output logic               res_valid,
   input  logic               res_ready,
   output rsp_type            res
);

   // Memories
   logic [VTX_W-1:0]  nbr_mem  [NBR_DEPTH];
   logic [DEG_W-1:0]  deg_mem  [MAX_VERTICES];
   logic [VTX_W-1:0]  hop_mem  [MAX_VERTICES];
   logic [VIDX_W-1:0] par_mem  [MAX_VERTICES];
   logic [VIDX_W-1:0] fifo_mem [MAX_VERTICES];
   logic [VIDX_W-1:0] path_mem [MAX_VERTICES];

   // Control and working registers
   state_type          state_ff, state_in;
   logic [VTX_W-1:0]   a_ff, a_in, b_ff, b_in;
   rsp_type            res_ff, res_in;
   logic [DEG_W-1:0]   da_ff, da_in, d_ff, d_in, k_ff, k_in;
   logic [CNT_W-1:0]   head_ff, head_in, tail_ff, tail_in, cnt_ff, cnt_in, len_ff, len_in;
   logic [VIDX_W-1:0]  u_ff, u_in, p_ff, p_in;
   logic [VTX_W-1:0]   hu_ff, hu_in, v_ff, v_in, start_ff, start_in;
   logic [MAX_VERTICES-1:0] visited_ff, visited_in, deg_vld_ff, deg_vld_in;

   // Memory ports
   logic [NBR_AW-1:0]  nbr_ra, nbr_wa;
   logic [VIDX_W-1:0]  deg_ra, deg_wa, hop_ra, hop_wa, par_ra, par_wa;
   logic [VIDX_W-1:0]  fifo_ra, fifo_wa, path_ra, path_wa;
   logic               nbr_we, deg_we, hop_we, par_we, fifo_we, path_we;
   logic [VTX_W-1:0]   nbr_wd, hop_wd;
   logic [DEG_W-1:0]   deg_wd;
   logic [VIDX_W-1:0]  par_wd, fifo_wd, path_wd;
   logic [VTX_W-1:0]   nbr_q_ff, hop_q_ff;
   logic [DEG_W-1:0]   deg_q_ff;
   logic [VIDX_W-1:0]  par_q_ff, fifo_q_ff, path_q_ff;

   // Shared decode
   logic [VC_W-1:0]  n_live;
   logic             a_ok, b_ok, full, w_new;
   cmd_type          req_cmd;

   assign n_live  = (vertex_count > VC_W'(MAX_VERTICES)) ? VC_W'(MAX_VERTICES) : vertex_count;
   assign req_cmd = cmd_type'(req_command);
   assign a_ok    = VC_W'(req_vertex_a) < n_live;
   assign b_ok    = VC_W'(req_vertex_b) < n_live;
   assign full    = (a_ff == b_ff) ? ((DEG_W+1)'(da_ff) + (DEG_W+1)'(2) >
                                      (DEG_W+1)'(MAX_DEGREE))
                                   : (da_ff >= DEG_W'(MAX_DEGREE) ||
                                      deg_q_ff >= DEG_W'(MAX_DEGREE));
   assign w_new   = (VC_W'(nbr_q_ff) < n_live) && !visited_ff[nbr_q_ff[VIDX_W-1:0]];
   assign req_ready = (state_ff == S_IDLE);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_cmd)
                  CMD_ADD:    state_in = (a_ok && b_ok) ? E_RDA : S_EMIT;
                  CMD_SEARCH: state_in = a_ok ? S_INIT : S_EMIT;
                  CMD_QUERY:  state_in = a_ok ? Q_START : S_EMIT;
                  default:    state_in = S_EMIT;
               endcase
            end
         end
         S_EMIT:  if (res_ready) state_in = S_IDLE;
         E_RDA:   state_in = E_RDB;
         E_RDB:   state_in = E_CHK;
         E_CHK:   state_in = full ? S_EMIT : E_WRB;
         E_WRB:   state_in = S_EMIT;
         S_INIT:  state_in = S_POP;
         S_POP:   state_in = (head_ff == tail_ff) ? S_EMIT : S_U;
         S_U:     state_in = S_UD;
         S_UD:    state_in = S_NRD;
         S_NRD:   state_in = (k_ff == d_ff) ? S_POP : S_NCHK;
         S_NCHK:  state_in = S_NRD;
         Q_START: state_in = visited_ff[a_ff[VIDX_W-1:0]] ? Q_CHK : S_EMIT;
         Q_CHK:   state_in = (v_ff == start_ff || len_ff == CNT_W'(MAX_VERTICES)) ?
                             Q_OUT : Q_PAR;
         Q_PAR:   state_in = Q_CHK;
         Q_OUT:   state_in = Q_HOP;
         Q_HOP:   state_in = Q_EMIT;
         Q_EMIT: begin
            if (res_ready) state_in = (len_ff == CNT_W'(1)) ? S_IDLE : Q_OUT;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath, memory ports and result
   always_comb begin
      a_in = a_ff;  b_in = b_ff;  res_in = res_ff;
      da_in = da_ff;  d_in = d_ff;  k_in = k_ff;
      head_in = head_ff;  tail_in = tail_ff;  cnt_in = cnt_ff;  len_in = len_ff;
      u_in = u_ff;  p_in = p_ff;  hu_in = hu_ff;  v_in = v_ff;  start_in = start_ff;
      visited_in = visited_ff;  deg_vld_in = deg_vld_ff;
      nbr_ra = '0;  deg_ra = '0;  hop_ra = '0;  par_ra = '0;  fifo_ra = '0;  path_ra = '0;
      nbr_we = 1'b0;  nbr_wa = '0;  nbr_wd = '0;
      deg_we = 1'b0;  deg_wa = '0;  deg_wd = '0;
      hop_we = 1'b0;  hop_wa = '0;  hop_wd = '0;
      par_we = 1'b0;  par_wa = '0;  par_wd = '0;
      fifo_we = 1'b0; fifo_wa = '0; fifo_wd = '0;
      path_we = 1'b0; path_wa = '0; path_wd = '0;
      res_valid = 1'b0;
      res = res_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               a_in   = req_vertex_a;
               b_in   = req_vertex_b;
               res_in.status        = ST_OK;
               res_in.path_vertex   = req_vertex_a;
               res_in.hop_distance  = '0;
               res_in.reached       = 1'b0;
               res_in.reached_count = '0;
               res_in.last          = 1'b1;
               if (req_cmd == CMD_CLEAR) begin
                  visited_in = '0;
                  deg_vld_in = '0;
               end else if (!a_ok || (req_cmd == CMD_ADD && !b_ok)) begin
                  res_in.status = ST_RANGE;
               end
            end
         end
         S_EMIT: res_valid = 1'b1;
         // edge insertion
         E_RDA: deg_ra = a_ff[VIDX_W-1:0];
         E_RDB: begin
            deg_ra = b_ff[VIDX_W-1:0];
            da_in  = deg_q_ff;
         end
         E_CHK: begin
            if (full) begin
               res_in.status = ST_FULL;
            end else begin
               nbr_we = 1'b1;
               nbr_wa = nbr_addr(a_ff[VIDX_W-1:0], da_ff);
               nbr_wd = b_ff;
               deg_we = 1'b1;
               deg_wa = a_ff[VIDX_W-1:0];
               deg_wd = da_ff + DEG_W'(1);
               deg_vld_in[a_ff[VIDX_W-1:0]] = 1'b1;
               da_in  = (a_ff == b_ff) ? da_ff + DEG_W'(1) : deg_q_ff;
            end
         end
         E_WRB: begin
            nbr_we = 1'b1;
            nbr_wa = nbr_addr(b_ff[VIDX_W-1:0], da_ff);
            nbr_wd = a_ff;
            deg_we = 1'b1;
            deg_wa = b_ff[VIDX_W-1:0];
            deg_wd = da_ff + DEG_W'(1);
            deg_vld_in[b_ff[VIDX_W-1:0]] = 1'b1;
         end
         // search
         S_INIT: begin
            visited_in = '0;
            visited_in[a_ff[VIDX_W-1:0]] = 1'b1;
            hop_we  = 1'b1;  hop_wa  = a_ff[VIDX_W-1:0];  hop_wd = '0;
            par_we  = 1'b1;  par_wa  = a_ff[VIDX_W-1:0];  par_wd = a_ff[VIDX_W-1:0];
            fifo_we = 1'b1;  fifo_wa = '0;                fifo_wd = a_ff[VIDX_W-1:0];
            head_in = '0;
            tail_in = CNT_W'(1);
            cnt_in  = CNT_W'(1);
         end
         S_POP: begin
            if (head_ff == tail_ff) begin
               start_in             = a_ff;
               res_in.reached       = 1'b1;
               res_in.reached_count = RCNT_W'(cnt_ff);
            end else begin
               fifo_ra = head_ff[VIDX_W-1:0];
               head_in = head_ff + CNT_W'(1);
            end
         end
         S_U: begin
            u_in   = fifo_q_ff;
            deg_ra = fifo_q_ff;
            hop_ra = fifo_q_ff;
         end
         S_UD: begin
            d_in  = (deg_q_ff > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : deg_q_ff;
            hu_in = hop_q_ff;
            k_in  = '0;
         end
         S_NRD: begin
            if (k_ff != d_ff) begin
               nbr_ra = nbr_addr(u_ff, k_ff);
               k_in   = k_ff + DEG_W'(1);
            end
         end
         S_NCHK: begin
            if (w_new) begin
               visited_in[nbr_q_ff[VIDX_W-1:0]] = 1'b1;
               hop_we = 1'b1;  hop_wa = nbr_q_ff[VIDX_W-1:0];  hop_wd = hu_ff + VTX_W'(1);
               par_we = 1'b1;  par_wa = nbr_q_ff[VIDX_W-1:0];  par_wd = u_ff;
               if (tail_ff < CNT_W'(MAX_VERTICES)) begin
                  fifo_we = 1'b1;
                  fifo_wa = tail_ff[VIDX_W-1:0];
                  fifo_wd = nbr_q_ff[VIDX_W-1:0];
                  tail_in = tail_ff + CNT_W'(1);
               end
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         // path query: walk parents, then replay backward
         Q_START: begin
            path_we = 1'b1;
            path_wa = '0;
            path_wd = a_ff[VIDX_W-1:0];
            len_in  = CNT_W'(1);
            v_in    = a_ff;
         end
         Q_CHK: par_ra = v_ff[VIDX_W-1:0];
         Q_PAR: begin
            v_in    = VTX_W'(par_q_ff);
            path_we = 1'b1;
            path_wa = len_ff[VIDX_W-1:0];
            path_wd = par_q_ff;
            len_in  = len_ff + CNT_W'(1);
         end
         Q_OUT: begin
            len_in  = len_ff;
            path_ra = VIDX_W'(len_ff - CNT_W'(1));
         end
         Q_HOP: begin
            p_in   = path_q_ff;
            hop_ra = path_q_ff;
         end
         Q_EMIT: begin
            hop_ra    = p_ff;
            res_valid = 1'b1;
            res.status        = ST_OK;
            res.path_vertex   = VTX_W'(p_ff);
            res.hop_distance  = hop_q_ff;
            res.reached       = 1'b1;
            res.reached_count = '0;
            res.last          = (len_ff == CNT_W'(1));
            if (res_ready) len_in = len_ff - CNT_W'(1);
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         start_ff   <= '0;
         visited_ff <= '0;
         deg_vld_ff <= '0;
      end else begin
         state_ff   <= state_in;
         start_ff   <= start_in;
         visited_ff <= visited_in;
         deg_vld_ff <= deg_vld_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      a_ff    <= a_in;     b_ff    <= b_in;     res_ff <= res_in;
      da_ff   <= da_in;    d_ff    <= d_in;     k_ff   <= k_in;
      head_ff <= head_in;  tail_ff <= tail_in;  cnt_ff <= cnt_in;  len_ff <= len_in;
      u_ff    <= u_in;     p_ff    <= p_in;     hu_ff  <= hu_in;   v_ff   <= v_in;
   end

   // Memory writes and registered reads
   always_ff @(posedge clock) begin
      if (nbr_we)  nbr_mem[nbr_wa]   <= nbr_wd;
      if (deg_we)  deg_mem[deg_wa]   <= deg_wd;
      if (hop_we)  hop_mem[hop_wa]   <= hop_wd;
      if (par_we)  par_mem[par_wa]   <= par_wd;
      if (fifo_we) fifo_mem[fifo_wa] <= fifo_wd;
      if (path_we) path_mem[path_wa] <= path_wd;
      nbr_q_ff  <= nbr_mem[nbr_ra];
      deg_q_ff  <= deg_vld_ff[deg_ra] ? deg_mem[deg_ra] : '0;
      hop_q_ff  <= hop_mem[hop_ra];
      par_q_ff  <= par_mem[par_ra];
      fifo_q_ff <= fifo_mem[fifo_ra];
      path_q_ff <= path_mem[path_ra];
   end

endmodule

// ===== design/bfs_shortest_path_engine.sv =====
// Top level: vertex count register, sequencer core and result register.
//
//  channel | ports                         | transfer when
//  --------+-------------------------------+--------------------------
//  request | req_valid/req_ready, req_*    | req_valid && req_ready
//  result  | rsp_valid/rsp_ready, rsp_*    | rsp_valid && rsp_ready
//  config  | csr_wr_en, csr_wr_data        | csr_wr_en
//
// Clear and rejected commands go straight to the result; add edge reads both degrees,
// checks for room, then writes both neighbor list entries. Search pops each reached
// vertex, reads its degree and hop, then reads and checks its neighbor entries in turn.
// Path query walks parents back to the source, then emits the path vertex by vertex.
// Reset is synchronous; degrees and visited marks clear at once, no sweep.
// A stalled result holds the sequencer; one result waits in the output register.
`timescale 1ns / 1ps
module bfs_shortest_path_engine import bsp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [CMD_W-1:0]   req_command,
   input  logic [VTX_W-1:0]   req_vertex_a,
   input  logic [VTX_W-1:0]   req_vertex_b,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [VTX_W-1:0]   rsp_path_vertex,
   output logic [VTX_W-1:0]   rsp_hop_distance,
   output logic               rsp_reached,
   output logic [RCNT_W-1:0]  rsp_reached_count,
   output logic               rsp_last,
   input  logic               csr_wr_en,
   input  logic [VC_W-1:0]    csr_wr_data
);

   logic [VC_W-1:0] vertex_count_ff;
   logic            res_valid, res_ready;
   rsp_type         res;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_ff, rsp_in;

   // Vertex count register
   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= VC_W'(MAX_VERTICES);
      end else if (csr_wr_en) begin
         vertex_count_ff <= csr_wr_data;
      end
   end

   bsp_core u_core (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_command  (req_command),
      .req_vertex_a (req_vertex_a),
      .req_vertex_b (req_vertex_b),
      .vertex_count (vertex_count_ff),
      .res_valid    (res_valid),
      .res_ready    (res_ready),
      .res          (res)
   );

   // Output register
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_ff.status;
   assign rsp_path_vertex   = rsp_ff.path_vertex;
   assign rsp_hop_distance  = rsp_ff.hop_distance;
   assign rsp_reached       = rsp_ff.reached;
   assign rsp_reached_count = rsp_ff.reached_count;
   assign rsp_last          = rsp_ff.last;

endmodule
